FILE: src/ors_pkg.sv
// Package for the 1-Wire ROM search engine: search state type, status and
// request kind codes, and limits of the search tree walk. No dependencies.
package ors_pkg;

  localparam int unsigned ROM_W = 64;
  localparam int unsigned POS_W = 7;
  localparam int unsigned FAM_W = 4;
  localparam int unsigned CMD_W = 8;

  localparam logic [POS_W-1:0] ROM_BITS_END = POS_W'(65);
  localparam logic [POS_W-1:0] FAMILY_LIMIT = POS_W'(9);
  localparam logic [CMD_W-1:0] SEARCH_CMD_RESET = 8'hF0;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_START = 2'd1,
    KIND_PAIR  = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEARED  = 3'd0,
    ST_SEND_CMD = 3'd1,
    ST_BRANCH   = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NONE     = 3'd4,
    ST_BIT_ERR  = 3'd5,
    ST_OVER     = 3'd6,
    ST_IGNORED  = 3'd7
  } status_t;

  typedef struct packed {
    logic [ROM_W-1:0] rom;
    logic [POS_W-1:0] last_bp;
    logic [FAM_W-1:0] fam_bp;
    logic             enum_done;
    logic [POS_W-1:0] bit_pos;
    logic [POS_W-1:0] pass_zero;
    logic             pass_active;
  } search_state_t;

  typedef struct packed {
    status_t          status;
    logic [CMD_W-1:0] command_byte;
    logic             branch_bit;
  } step_result_t;

  // Clear the search state; the ROM register keeps its contents.
  function automatic search_state_t clear_search(search_state_t s);
    search_state_t r;
    r             = s;
    r.last_bp     = '0;
    r.fam_bp      = '0;
    r.enum_done   = 1'b0;
    r.bit_pos     = POS_W'(1);
    r.pass_zero   = '0;
    r.pass_active = 1'b0;
    return r;
  endfunction

endpackage

FILE: src/ors_step.sv
// One search step: next search state and result for one request.
// Combinational; depends on ors_pkg.
module ors_step
  import ors_pkg::*;
(
  input  search_state_t    st,
  input  logic [1:0]       kind,
  input  logic             no_presence,
  input  logic             id_bit,
  input  logic             complement_bit,
  input  logic [CMD_W-1:0] search_cmd,
  output search_state_t    st_nxt,
  output step_result_t     res
);

  logic [POS_W-1:0] pos_inc;
  logic [5:0]       idx;
  logic             dir;
  search_state_t    walk;

  assign idx     = 6'(st.bit_pos - POS_W'(1));
  assign pos_inc = st.bit_pos + POS_W'(1);

  always_comb begin
    if (id_bit != complement_bit) begin
      dir = id_bit;
    end else if (st.bit_pos < st.last_bp) begin
      dir = st.rom[idx];
    end else begin
      dir = (st.bit_pos == st.last_bp);
    end
  end

  always_comb begin
    walk = st;
    walk.rom[idx] = dir;
    if (id_bit == complement_bit && !dir) begin
      walk.pass_zero = st.bit_pos;
      if (st.bit_pos < FAMILY_LIMIT) begin
        walk.fam_bp = FAM_W'(st.bit_pos);
      end
    end
    walk.bit_pos = pos_inc;
    if (pos_inc >= ROM_BITS_END) begin
      walk.pass_active = 1'b0;
      walk.bit_pos     = POS_W'(1);
      walk.last_bp     = walk.pass_zero;
      if (walk.pass_zero == '0) begin
        walk.enum_done = 1'b1;
      end
    end
  end

  always_comb begin
    st_nxt           = st;
    res.status       = ST_IGNORED;
    res.command_byte = '0;
    res.branch_bit   = 1'b0;
    unique case (kind_t'(kind))
      KIND_CLEAR: begin
        st_nxt     = clear_search(st);
        res.status = ST_CLEARED;
      end
      KIND_START: begin
        priority if (st.enum_done) begin
          st_nxt     = clear_search(st);
          res.status = ST_OVER;
        end else if (no_presence) begin
          st_nxt     = clear_search(st);
          res.status = ST_NONE;
        end else begin
          st_nxt.pass_active = 1'b1;
          st_nxt.bit_pos     = POS_W'(1);
          st_nxt.pass_zero   = '0;
          res.status         = ST_SEND_CMD;
          res.command_byte   = search_cmd;
        end
      end
      KIND_PAIR: begin
        if (st.pass_active) begin
          if (id_bit && complement_bit) begin
            st_nxt     = clear_search(st);
            res.status = ST_BIT_ERR;
          end else begin
            res.branch_bit = dir;
            if (pos_inc >= ROM_BITS_END) begin
              if (walk.rom[7:0] == 8'h00) begin
                st_nxt     = clear_search(walk);
                res.status = ST_OVER;
              end else begin
                st_nxt     = walk;
                res.status = ST_FOUND;
              end
            end else begin
              st_nxt     = walk;
              res.status = ST_BRANCH;
            end
          end
        end
      end
      default: begin
        res.status = ST_IGNORED;
      end
    endcase
  end

endmodule

FILE: src/onewire_rom_search_engine_unit.sv
// Top level of the 1-Wire ROM search engine: input register, search state,
// result register. Depends on ors_pkg and ors_step.
//
//  channel | direction | tdata                                  | tuser
//  in_     | request   | no_presence, id_bit, complement_bit    | kind
//  out_    | result    | command_byte, branch_bit, rom_code,    | status
//          |           | last_device, family_discrepancy        |
//  cfg_    | write     | search_command                         | -
//
// One request per cycle unless the result stalls, one result per request; a request
// goes through the input register, then the result register, and the search state
// updates as it moves between them. A stalled result holds; one more request is
// taken into the input register meanwhile. Reset is synchronous.
module onewire_rom_search_engine_unit
  import ors_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] no_presence, [1] id_bit, [2] complement_bit
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [7:0] command_byte, [8] branch_bit, [72:9] rom_code,
                                  // [73] last_device, [77:74] family_discrepancy
  output logic [2:0]  out_tuser,  // [2:0] status
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  logic             in_valid_r;
  logic [1:0]       in_kind_r;
  logic [2:0]       in_bits_r;
  logic             out_valid_r;
  step_result_t     res_r;
  logic [ROM_W-1:0] out_rom_r;
  logic             out_last_r;
  logic [FAM_W-1:0] out_fam_r;
  logic [CMD_W-1:0] cmd_r;
  search_state_t    state_r;
  search_state_t    state_nxt;
  step_result_t     res_nxt;
  logic             advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  ors_step u_step (
    .st             (state_r),
    .kind           (in_kind_r),
    .no_presence    (in_bits_r[0]),
    .id_bit         (in_bits_r[1]),
    .complement_bit (in_bits_r[2]),
    .search_cmd     (cmd_r),
    .st_nxt         (state_nxt),
    .res            (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cmd_r       <= SEARCH_CMD_RESET;
      state_r     <= clear_search('0);
    end else begin
      if (cfg_we) begin
        cmd_r <= cfg_wdata;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_kind_r <= in_tuser;
      in_bits_r <= in_tdata[2:0];
    end
    if (advance) begin
      res_r      <= res_nxt;
      out_rom_r  <= state_nxt.rom;
      out_last_r <= state_nxt.enum_done;
      out_fam_r  <= state_nxt.fam_bp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {2'b00, out_fam_r, out_last_r, out_rom_r, res_r.branch_bit,
                       res_r.command_byte};

endmodule

FILE: dv/onewire_rom_search_engine_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for onewire_rom_search_engine_unit: emulates wired-AND buses of devices,
// predicts each result of the ROM search walk and checks it field by field.
// Depends on ors_pkg and the RTL top level.
module onewire_rom_search_engine_unit_tb;
  import ors_pkg::*;

  localparam int STALL_LIMIT = 400;

  typedef struct packed {
    kind_t kind;
    logic  no_presence;
    logic  id_bit;
    logic  complement_bit;
  } request_t;

  typedef struct packed {
    logic [7:0]  command;
    logic [63:0] rom;
    logic [6:0]  last_disc;
    logic [3:0]  family_zero;
    logic        done;
    logic [6:0]  pos;
    logic [6:0]  pass_zero;
    logic        active;
  } walk_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  command_byte;
    logic        branch_bit;
    logic [63:0] rom_code;
    logic        last_device;
    logic [3:0]  family_disc;
  } outcome_t;

  typedef struct packed {
    walk_t    walk;
    outcome_t outcome;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  request_t    pending_reqs[$];
  outcome_t    expected_results[$];
  walk_t       model_walk;
  walk_t       bus_walk;
  logic [63:0] device_ids[8];
  logic        in_acc = 1'b0;
  bit          idle_on = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          stall_cycles = 0;
  int          queued = 0;
  int          checked = 0;
  int          mismatches = 0;
  int          bus_sets = 0;
  int          status_seen[8];

  onewire_rom_search_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic walk_t drop_search(walk_t w);
    w.last_disc   = '0;
    w.family_zero = '0;
    w.done        = 1'b0;
    w.pos         = 7'd1;
    w.pass_zero   = '0;
    w.active      = 1'b0;
    return w;
  endfunction

  function automatic walk_t fresh_walk();
    walk_t w;
    w         = '0;
    w.command = SEARCH_CMD_RESET;
    return drop_search(w);
  endfunction

  function automatic step_t search_step(walk_t w, request_t r);
    outcome_t   o;
    step_t      s;
    logic       dir;
    logic [6:0] below;
    logic [7:0] next_pos;
    o        = '0;
    o.status = ST_IGNORED;
    case (r.kind)
      KIND_CLEAR: begin
        w        = drop_search(w);
        o.status = ST_CLEARED;
      end
      KIND_START: begin
        if (w.done) begin
          w        = drop_search(w);
          o.status = ST_OVER;
        end else if (r.no_presence) begin
          w        = drop_search(w);
          o.status = ST_NONE;
        end else begin
          w.active       = 1'b1;
          w.pos          = 7'd1;
          w.pass_zero    = '0;
          o.status       = ST_SEND_CMD;
          o.command_byte = w.command;
        end
      end
      KIND_PAIR: begin
        if (w.active && r.id_bit && r.complement_bit) begin
          w        = drop_search(w);
          o.status = ST_BIT_ERR;
        end else if (w.active) begin
          below = w.pos - 7'd1;
          if (r.id_bit != r.complement_bit) begin
            dir = r.id_bit;
          end else begin
            if (w.pos < w.last_disc) dir = w.rom[below[5:0]];
            else dir = (w.pos == w.last_disc);
            if (!dir) begin
              w.pass_zero = w.pos;
              if (w.pos < FAMILY_LIMIT) w.family_zero = w.pos[3:0];
            end
          end
          w.rom[below[5:0]] = dir;
          o.branch_bit      = dir;
          next_pos          = {1'b0, w.pos} + 8'd1;
          w.pos             = next_pos[6:0];
          if (next_pos >= {1'b0, ROM_BITS_END}) begin
            w.active    = 1'b0;
            w.pos       = 7'd1;
            w.last_disc = w.pass_zero;
            if (w.last_disc == '0) w.done = 1'b1;
            if (w.rom[7:0] == 8'h00) begin
              w        = drop_search(w);
              o.status = ST_OVER;
            end else begin
              o.status = ST_FOUND;
            end
          end else begin
            o.status = ST_BRANCH;
          end
        end
      end
      default: ;
    endcase
    o.rom_code    = w.rom;
    o.last_device = w.done;
    o.family_disc = w.family_zero;
    s.walk        = w;
    s.outcome     = o;
    return s;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Request driver
  always @(negedge clk) begin
    if (in_acc) pending_reqs.pop_front();
    if (in_tvalid && !in_acc) begin
      // request still waiting for acceptance, hold it
    end else if (in_gap > 0) begin
      in_gap--;
      in_tvalid <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      in_gap = $urandom_range(1, 17) - 1;
      in_tvalid <= 1'b0;
    end else if (pending_reqs.size() != 0) begin
      in_tvalid <= 1'b1;
      in_tdata  <= {5'b0, pending_reqs[0].complement_bit, pending_reqs[0].id_bit,
                    pending_reqs[0].no_presence};
      in_tuser  <= pending_reqs[0].kind;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Result sink
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(1, 17) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor, predictor and watchdog
  always @(posedge clk) begin : monitor
    request_t r;
    step_t    s;
    outcome_t want;
    if (!rst_n) begin
      model_walk = fresh_walk();
      in_acc <= 1'b0;
    end else begin
      if (cfg_we) model_walk.command = cfg_wdata;
      in_acc <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        r.kind           = kind_t'(in_tuser);
        r.no_presence    = in_tdata[0];
        r.id_bit         = in_tdata[1];
        r.complement_bit = in_tdata[2];
        s                = search_step(model_walk, r);
        model_walk       = s.walk;
        expected_results.push_back(s.outcome);
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding, status %0d", out_tuser);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(want.status), 64'(out_tuser));
          check_field("command_byte", 64'(want.command_byte), 64'(out_tdata[7:0]));
          check_field("branch_bit", 64'(want.branch_bit), 64'(out_tdata[8]));
          check_field("rom_code", want.rom_code, out_tdata[72:9]);
          check_field("last_device", 64'(want.last_device), 64'(out_tdata[73]));
          check_field("family_discrepancy", 64'(want.family_disc),
                      64'(out_tdata[77:74]));
          status_seen[want.status]++;
          checked++;
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic push_request(kind_t k, logic np, logic ib, logic cb, output outcome_t o);
    request_t r;
    step_t    s;
    r.kind           = k;
    r.no_presence    = np;
    r.id_bit         = ib;
    r.complement_bit = cb;
    s                = search_step(bus_walk, r);
    bus_walk         = s.walk;
    o                = s.outcome;
    pending_reqs.push_back(r);
    queued++;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_search_cmd(logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    bus_walk.command = value;
  endtask

  // Build a bus of 1..5 related devices and enumerate it pass by pass, with
  // occasional stray requests that may break the walk.
  task automatic scan_bus(int limit);
    logic [63:0] base;
    logic [63:0] id;
    logic [7:0]  live;
    logic [6:0]  pos0;
    logic        ones;
    logic        zeros;
    bit          broken;
    outcome_t    o;
    int          n, i, j, k, b, pass;
    base = {$urandom(), $urandom()};
    n    = $urandom_range(1, 5);
    for (i = 0; i < n; i++) begin
      id = base;
      for (j = $urandom_range(0, 3); j > 0; j--) begin
        k     = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 63);
        id[k] = ~id[k];
      end
      device_ids[i] = id;
    end
    if ($urandom_range(0, 3) == 0) begin
      k                   = $urandom_range(0, n - 1);
      device_ids[k][7:0] = 8'h00;
    end
    bus_sets++;
    for (pass = 0; pass < 2 * n + 2 && !bus_walk.done && queued < limit; pass++) begin
      push_request(KIND_START, 1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), o);
      live   = 8'((1 << n) - 1);
      broken = 1'b0;
      for (b = 0; b < 64 && !broken; b++) begin
        if ($urandom_range(0, 39) == 0) begin
          pos0 = bus_walk.pos;
          push_request(kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), o);
          broken = !bus_walk.active || bus_walk.pos != pos0;
        end
        if (!broken) begin
          ones  = 1'b1;
          zeros = 1'b1;
          for (i = 0; i < n; i++) begin
            if (live[i]) begin
              ones  = ones & device_ids[i][b];
              zeros = zeros & ~device_ids[i][b];
            end
          end
          push_request(KIND_PAIR, 1'($urandom_range(0, 1)), ones, zeros, o);
          for (i = 0; i < n; i++) if (device_ids[i][b] != o.branch_bit) live[i] = 1'b0;
        end
      end
    end
    if (bus_walk.done)
      push_request(KIND_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), o);
  endtask

  initial begin
    outcome_t o;
    int       stop_at;
    bus_walk = fresh_walk();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n   <= 1'b1;
    idle_on = 1'b1;

    // directed: stray pairs, reserved kind, no presence, branches, restart, 1/1, clear
    push_request(KIND_PAIR,  1'b1, 1'b1, 1'b0, o);
    push_request(KIND_RSVD,  1'b1, 1'b1, 1'b1, o);
    push_request(KIND_START, 1'b1, 1'b0, 1'b0, o);
    push_request(KIND_START, 1'b0, 1'b1, 1'b1, o);
    push_request(KIND_PAIR,  1'b0, 1'b0, 1'b1, o);
    push_request(KIND_PAIR,  1'b1, 1'b1, 1'b0, o);
    push_request(KIND_PAIR,  1'b0, 1'b0, 1'b0, o);
    push_request(KIND_START, 1'b0, 1'b0, 1'b0, o);
    push_request(KIND_PAIR,  1'b0, 1'b0, 1'b0, o);
    push_request(KIND_PAIR,  1'b0, 1'b1, 1'b1, o);
    push_request(KIND_PAIR,  1'b0, 1'b0, 1'b1, o);
    push_request(KIND_RSVD,  1'b0, 1'b0, 1'b0, o);
    push_request(KIND_CLEAR, 1'b1, 1'b1, 1'b1, o);
    push_request(KIND_START, 1'b0, 1'b0, 1'b0, o);
    push_request(KIND_PAIR,  1'b1, 1'b0, 1'b0, o);
    push_request(KIND_PAIR,  1'b0, 1'b1, 1'b0, o);
    push_request(KIND_CLEAR, 1'b0, 1'b0, 1'b0, o);
    push_request(KIND_PAIR,  1'b1, 1'b0, 1'b1, o);
    wait_idle();

    write_search_cmd(8'h00);
    stop_at = queued + 180;
    while (queued < stop_at) scan_bus(stop_at);
    wait_idle();

    write_search_cmd(8'hFF);
    stop_at = queued + 180;
    while (queued < stop_at) scan_bus(stop_at);
    wait_idle();

    // alarm search command, full throughput on both sides
    write_search_cmd(8'hEC);
    idle_on = 1'b0;
    stop_at = queued + 180;
    while (queued < stop_at) scan_bus(stop_at);

    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("checked %0d results over %0d emulated buses and 4 command settings",
             checked, bus_sets);
    $display("devices found %0d, enumerations ended %0d, bit errors %0d, no presence %0d",
             status_seen[ST_FOUND], status_seen[ST_OVER], status_seen[ST_BIT_ERR],
             status_seen[ST_NONE]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
